@@ design/md5_message_digest_core_defines.svh @@
// Assertion macros for the MD5 digest core checker.
`ifndef MD5_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MD5_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/md5_pkg.sv @@
// Types, constants and round tables for the MD5 digest core.
package md5_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] chain_t;

	localparam word_t IV_A = 32'h67452301;
	localparam word_t IV_B = 32'hefcdab89;
	localparam word_t IV_C = 32'h98badcfe;
	localparam word_t IV_D = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [1:0] WORD_D = 2'd3;
	localparam logic [3:0] LAST_BUF_WORD = 4'd15;
	localparam logic [3:0] LEN_LO_WORD = 4'd14;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [5:0] LAST_BYTE_POS = 6'd63;

	// Top-level sequencer
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_PAD,
		SEQ_HASH,
		SEQ_EMIT
	} seq_state_t;

	// What follows a finished compression
	typedef enum logic [1:0] {
		ACT_IDLE,
		ACT_PAD,
		ACT_PAD2,
		ACT_EMIT
	} action_t;

	// Compression unit sequencer
	typedef enum logic [1:0] {
		CMP_IDLE,
		CMP_FETCH,
		CMP_ROUND,
		CMP_FOLD
	} cmp_state_t;

	typedef struct packed {
		logic       start;
		logic       init_chain;
		logic       wr_en;
		logic [3:0] wr_addr;
		word_t      wr_data;
	} cmp_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cmp_stat_t;

	// Message word used by a round
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] r;
		logic [3:0] g;
		r = rnd[3:0];
		case (rnd[5:4])
			2'd0: g = r;
			2'd1: g = r * 4'd5 + 4'd1;
			2'd2: g = r * 4'd3 + 4'd5;
			2'd3: g = r * 4'd7;
			default: g = r;
		endcase
		return g;
	endfunction

	// Rotate amount, indexed by {round group, round low bits}
	function automatic logic [4:0] rot_amt(input logic [3:0] idx);
		logic [4:0] s;
		case (idx)
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} << n;
		return t[63:32];
	endfunction

	// Additive round constants
	function automatic word_t round_const(input logic [5:0] rnd);
		word_t k;
		case (rnd)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

@@ design/md5_if.sv @@
// Valid/ready stream interfaces for the MD5 digest core.
interface md5_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source(output valid, output data_byte, output has_byte, output end_of_message,
		input ready);
	modport sink(input valid, input data_byte, input has_byte, input end_of_message,
		output ready);
endinterface

interface md5_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source(output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink(input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

@@ design/md5_compress.sv @@
// MD5 compression unit: block buffer, one round per cycle, chaining words.
module md5_compress (
	input  logic               clk,
	input  logic               arst_n,
	input  md5_pkg::cmp_ctrl_t ctrl,
	output md5_pkg::cmp_stat_t stat,
	output md5_pkg::chain_t    chain
);
	import md5_pkg::*;

	cmp_state_t state_q, state_d;
	logic [5:0] rnd_q;
	word_t      a_q, b_q, c_q, d_q;
	chain_t     chain_q;
	word_t      buf_mem [16];
	word_t      rdata_q;
	logic [3:0] rd_addr;
	word_t      f;
	word_t      sum;
	word_t      b_new;

	// Block buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			buf_mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		rdata_q <= buf_mem[rd_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CMP_IDLE:  if (ctrl.start) state_d = CMP_FETCH;
			CMP_FETCH: state_d = CMP_ROUND;
			CMP_ROUND: if (rnd_q == LAST_ROUND) state_d = CMP_FOLD;
			CMP_FOLD:  state_d = CMP_IDLE;
			default:   state_d = CMP_IDLE;
		endcase
	end

	// Outputs: prefetch address and status
	always_comb begin
		rd_addr = msg_index(6'd0);
		stat.busy = 1'b1;
		stat.done = 1'b0;
		case (state_q)
			CMP_IDLE:  stat.busy = 1'b0;
			CMP_FETCH: rd_addr = msg_index(6'd0);
			CMP_ROUND: rd_addr = msg_index(rnd_q + 6'd1);
			CMP_FOLD:  stat.done = 1'b1;
			default:   stat.busy = 1'b0;
		endcase
	end

	// Round function for the current group
	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (d_q & b_q) | (~d_q & c_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			2'd3:    f = c_q ^ (b_q | ~d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		sum = a_q + f + rdata_q + round_const(rnd_q);
		b_new = b_q + rotl(sum, rot_amt({rnd_q[5:4], rnd_q[1:0]}));
	end

	// Sequencer state and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CMP_IDLE;
			rnd_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CMP_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end else begin
				rnd_q <= '0;
			end
		end
	end

	// Chaining words: load initial values, fold in the working words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {IV_D, IV_C, IV_B, IV_A};
		end else if (ctrl.init_chain) begin
			chain_q <= {IV_D, IV_C, IV_B, IV_A};
		end else if (state_q == CMP_FOLD) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
	end

	// Working words: load at start, rotate through each round
	always_ff @(posedge clk) begin
		if (state_q == CMP_IDLE && ctrl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == CMP_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_new;
		end
	end

	assign chain = chain_q;

endmodule

@@ design/md5_message_digest_core.sv @@
// MD5 digest core: byte packing, padding sequencer and digest output.
//
//  channel | dir | payload                                 | transaction
//  in_ch   | in  | data_byte[7:0], has_byte, end_of_message | one message byte or end mark
//  out_ch  | out | digest_word[31:0], word_index, last_word | one digest word, A to D
//
// The byte that fills a block starts a compression: one prefetch, 64 rounds of
// the shared round unit, one fold into the chaining words.
// An end item takes the padding sweep (one buffer word a cycle), one or two
// compressions, then four output transactions.
// in_ch.ready drops after a block's last byte until its fold, and after an end item
// until word D is out.
// Output stalls hold the current digest word; reset loads the initial chaining words.
module md5_message_digest_core (
	input logic      clk,
	input logic      arst_n,
	md5_in_if.sink   in_ch,
	md5_out_if.source out_ch
);
	import md5_pkg::*;

	seq_state_t  state_q, state_d;
	action_t     action_q;
	logic [5:0]  bpos_q;
	logic [5:0]  bpos_d;
	logic [60:0] len_q;
	word_t       acc_q;
	logic [3:0]  widx_q;
	logic        first_q;
	logic        lenblk_q;
	logic [1:0]  oidx_q;
	cmp_ctrl_t   ctrl;
	cmp_stat_t   stat;
	chain_t      chain;
	logic        in_acc;
	logic        out_acc;
	logic        full;
	logic [4:0]  lane_sh;
	word_t       base_word;
	word_t       byte_word;
	word_t       pad_word;

	md5_compress u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.chain  (chain)
	);

	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign full = in_ch.has_byte && (bpos_q == LAST_BYTE_POS);
	assign bpos_d = in_ch.has_byte ? bpos_q + 6'd1 : bpos_q;

	// Merge the byte (or pad mark) into the partial word
	assign lane_sh = {bpos_q[1:0], 3'b000};
	assign base_word = (bpos_q[1:0] == 2'd0) ? '0 : acc_q;
	assign byte_word = base_word | ({24'h0, in_ch.data_byte} << lane_sh);

	// Padding sweep word: pad mark, zero fill or bit length
	always_comb begin
		if (lenblk_q && widx_q == LEN_LO_WORD) begin
			pad_word = {len_q[28:0], 3'b000};
		end else if (lenblk_q && widx_q == LAST_BUF_WORD) begin
			pad_word = len_q[60:29];
		end else if (first_q) begin
			pad_word = base_word | ({24'h0, PAD_BYTE} << lane_sh);
		end else begin
			pad_word = '0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (in_acc && full) begin
					state_d = SEQ_HASH;
				end else if (in_acc && in_ch.end_of_message) begin
					state_d = SEQ_PAD;
				end
			end
			SEQ_PAD: if (widx_q == LAST_BUF_WORD) state_d = SEQ_HASH;
			SEQ_HASH: begin
				if (stat.done) begin
					case (action_q)
						ACT_IDLE: state_d = SEQ_IDLE;
						ACT_PAD:  state_d = SEQ_PAD;
						ACT_PAD2: state_d = SEQ_PAD;
						ACT_EMIT: state_d = SEQ_EMIT;
						default:  state_d = SEQ_IDLE;
					endcase
				end
			end
			SEQ_EMIT: if (out_acc && oidx_q == WORD_D) state_d = SEQ_IDLE;
			default: state_d = SEQ_IDLE;
		endcase
	end

	// Outputs: handshakes and compression unit control
	always_comb begin
		in_ch.ready = 1'b0;
		out_ch.valid = 1'b0;
		ctrl = '0;
		ctrl.wr_addr = widx_q;
		ctrl.wr_data = pad_word;
		case (state_q)
			SEQ_IDLE: begin
				in_ch.ready = 1'b1;
				ctrl.wr_en = in_acc && in_ch.has_byte;
				ctrl.wr_addr = bpos_q[5:2];
				ctrl.wr_data = byte_word;
				ctrl.start = in_acc && full;
			end
			SEQ_PAD: begin
				ctrl.wr_en = 1'b1;
				ctrl.start = (widx_q == LAST_BUF_WORD);
			end
			SEQ_HASH: ;
			SEQ_EMIT: begin
				out_ch.valid = 1'b1;
				ctrl.init_chain = out_acc && (oidx_q == WORD_D);
			end
			default: ;
		endcase
	end

	assign out_ch.digest_word = chain[oidx_q];
	assign out_ch.word_index = oidx_q;
	assign out_ch.last_word = (oidx_q == WORD_D);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			action_q <= ACT_IDLE;
			bpos_q <= '0;
			len_q <= '0;
			widx_q <= '0;
			first_q <= 1'b0;
			lenblk_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				SEQ_IDLE: begin
					if (in_acc) begin
						// Absorb the byte and count it
						if (in_ch.has_byte) begin
							len_q <= len_q + 61'd1;
						end
						bpos_q <= bpos_d;
						if (full) begin
							action_q <= in_ch.end_of_message ? ACT_PAD : ACT_IDLE;
						end else if (in_ch.end_of_message) begin
							widx_q <= bpos_d[5:2];
							first_q <= 1'b1;
							lenblk_q <= (bpos_d[5:3] != 3'b111);
						end
					end
				end
				SEQ_PAD: begin
					// Advance the sweep; pick what follows the compression
					widx_q <= widx_q + 4'd1;
					first_q <= 1'b0;
					if (widx_q == LAST_BUF_WORD) begin
						action_q <= lenblk_q ? ACT_EMIT : ACT_PAD2;
					end
				end
				SEQ_HASH: begin
					if (stat.done) begin
						case (action_q)
							ACT_PAD: begin
								widx_q <= bpos_q[5:2];
								first_q <= 1'b1;
								lenblk_q <= (bpos_q[5:3] != 3'b111);
							end
							ACT_PAD2: begin
								widx_q <= '0;
								first_q <= 1'b0;
								lenblk_q <= 1'b1;
							end
							ACT_EMIT: oidx_q <= '0;
							ACT_IDLE: ;
							default: ;
						endcase
					end
				end
				SEQ_EMIT: begin
					if (out_acc) begin
						oidx_q <= oidx_q + 2'd1;
						if (oidx_q == WORD_D) begin
							bpos_q <= '0;
							len_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Partial word holds the bytes of the current buffer word
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.has_byte) begin
			acc_q <= byte_word;
		end
	end

endmodule

@@ design/md5_checker.sv @@
// Port-level checker for the MD5 digest core, bound to the top level.
`include "md5_message_digest_core_defines.svh"

module md5_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] word_index,
	input logic       last_word
);
	import md5_pkg::*;

	logic       out_acc;
	logic       is_d;
	logic [1:0] index_inc;

	assign out_acc = out_valid && out_ready;
	assign is_d = (word_index == WORD_D);
	assign index_inc = word_index + 2'd1;

	// Input side stays closed while the digest goes out
	`MD5_ASSERT_NOW(a_no_input_while_emit, out_valid, !in_ready, "input ready during output")

	// Final flag marks word D only
	`MD5_ASSERT_NOW(a_last_is_d, out_valid, last_word == is_d, "last_word mismatch")

	// Digest words follow in order A, B, C, D
	`MD5_ASSERT_NEXT(a_step, out_acc && !last_word, out_valid && word_index == $past(index_inc), "bad order")

	// After word D the core takes input again
	`MD5_ASSERT_NEXT(a_idle_after_d, out_acc && last_word, !out_valid && in_ready, "not idle after D")

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.word_index (out_ch.word_index),
	.last_word  (out_ch.last_word)
);
